>>> rtl/b2b_pkg.sv
// shared types, constants and functions of the blake2b hash engine
package b2b_pkg;

   localparam int BLOCK_BYTES = 128;
   localparam int OUT_BYTES   = 64;
   localparam int KEY_BYTES   = 64;
   localparam logic [63:0] PARAM_BASE = 64'h0000_0000_0101_0000;

   localparam logic [0:0] CSR_DIGEST_LEN = 1'd0;
   localparam logic [0:0] CSR_KEY_LEN    = 1'd1;

   typedef logic [63:0] word_type;
   typedef logic [3:0]  widx_type;

   function automatic word_type iv_word(input logic [2:0] i);
      word_type r;
      case (i)
         3'd0: r = 64'h6a09e667f3bcc908;
         3'd1: r = 64'hbb67ae8584caa73b;
         3'd2: r = 64'h3c6ef372fe94f82b;
         3'd3: r = 64'ha54ff53a5f1d36f1;
         3'd4: r = 64'h510e527fade682d1;
         3'd5: r = 64'h9b05688c2b3e6c1f;
         3'd6: r = 64'h1f83d9abfb41bd6b;
         default: r = 64'h5be0cd19137e2179;
      endcase
      return r;
   endfunction

   // message word index for round r, slot s
   function automatic widx_type sigma(input logic [3:0] r, input logic [3:0] s);
      logic [63:0] row;
      logic [3:0]  rr;
      rr = (r >= 4'd10) ? r - 4'd10 : r;
      case (rr)
         4'd0: row = 64'hfedcba9876543210;
         4'd1: row = 64'h357b20c16df984ae;
         4'd2: row = 64'h491763eadf250c8b;
         4'd3: row = 64'h8f04a562ebcd1397;
         4'd4: row = 64'hd386cb1efa427509;
         4'd5: row = 64'h91ef57d438b0a6c2;
         4'd6: row = 64'hb8293670a4def15c;
         4'd7: row = 64'ha2684f05931ce7bd;
         4'd8: row = 64'h5a417d2c803b9ef6;
         default: row = 64'h0dc3e9bf5167482a;
      endcase
      return row[s*4 +: 4];
   endfunction

   // work vector indexes a,b,c,d of mix g
   function automatic logic [15:0] mix_sel(input logic [2:0] g);
      logic [15:0] r;
      case (g)
         3'd0: r = {4'd12, 4'd8,  4'd4, 4'd0};
         3'd1: r = {4'd13, 4'd9,  4'd5, 4'd1};
         3'd2: r = {4'd14, 4'd10, 4'd6, 4'd2};
         3'd3: r = {4'd15, 4'd11, 4'd7, 4'd3};
         3'd4: r = {4'd15, 4'd10, 4'd5, 4'd0};
         3'd5: r = {4'd12, 4'd11, 4'd6, 4'd1};
         3'd6: r = {4'd13, 4'd8,  4'd7, 4'd2};
         default: r = {4'd14, 4'd9, 4'd4, 4'd3};
      endcase
      return r;
   endfunction

   function automatic word_type param_word(input logic [6:0] dl, input logic [6:0] kl);
      logic [6:0] d;
      logic [6:0] k;
      d = (dl == 7'd0) ? 7'd1 : ((dl > 7'd64) ? 7'd64 : dl);
      k = (kl > 7'd64) ? 7'd64 : kl;
      return PARAM_BASE ^ {49'd0, k, 8'd0} ^ {57'd0, d};
   endfunction

endpackage

>>> rtl/b2b_if.sv
// valid/ready stream interfaces of the blake2b hash engine
interface b2b_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] msg_word;
   logic [3:0]  valid_bytes;
   logic        last_word;
   modport source (output valid, msg_word, valid_bytes, last_word, input ready);
   modport sink   (input valid, msg_word, valid_bytes, last_word, output ready);
endinterface

interface b2b_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_word;
   logic [3:0]  digest_bytes;
   logic        digest_last;
   modport source (output valid, digest_word, digest_bytes, digest_last, input ready);
   modport sink   (input valid, digest_word, digest_bytes, digest_last, output ready);
endinterface

interface b2b_csr_if;
   logic       valid;
   logic       ready;
   logic [0:0] index;
   logic [6:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/b2b_ram.sv
// generic one-write one-read synchronous ram
module b2b_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> rtl/blake2b_hash_engine.sv
// top level of the blake2b hash engine: packing, compression sequencer, digest out
// a compression runs a setup step, 12 rounds of 8 mixes and a fold step, with one mix unit
// a beat holds the input while its bytes are packed by buffer read-modify-write, and
// through a compression when a byte spills past a full block; the last beat pads with
// zero bytes, compresses, then sends one digest beat per cycle while the receiver is ready
// synchronous active-high reset restores default lengths, chain value and counters
module blake2b_hash_engine (
   input logic clock,
   input logic reset,
   b2b_req_if.sink   req,
   b2b_rsp_if.source rsp,
   b2b_csr_if.sink   csr
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_PACK, ST_INIT, ST_RD0, ST_RD1, ST_RD2, ST_MIX, ST_FIN, ST_OUT
   } state_type;

   state_type   state_ff;
   logic [6:0]  dlen_ff, klen_ff;
   logic [63:0] cv_ff [8];
   logic [63:0] v_ff [16];
   logic [127:0] cnt_ff;
   logic [7:0]  fill_ff;
   logic [63:0] word_ff;
   logic [3:0]  nb_ff;
   logic [3:0]  pos_ff;
   logic        last_ff;
   logic        final_ff;
   logic [3:0]  round_ff;
   logic [2:0]  g_ff;
   logic [3:0]  sub_ff;
   logic [63:0] m0_ff, m1_ff;
   logic [2:0]  ow_ff;

   // block buffer memory
   logic        bw_en;
   logic [3:0]  bw_addr, br_addr;
   logic [63:0] bw_data, br_data;

   b2b_ram #(.WIDTH(64), .DEPTH(16)) u_buf (
      .clock, .wr_en(bw_en), .wr_addr(bw_addr), .wr_data(bw_data),
      .rd_addr(br_addr), .rd_data(br_data)
   );

   logic [6:0] dl_eff;
   assign dl_eff = (dlen_ff == 7'd0) ? 7'd1 : ((dlen_ff > 7'd64) ? 7'd64 : dlen_ff);
   logic [2:0] last_ow;
   assign last_ow = 3'((dl_eff - 7'd1) >> 3);

   // mix indexes
   logic [15:0] sel;
   logic [3:0]  ia, ib, ic, id;
   assign sel = b2b_pkg::mix_sel(g_ff);
   assign {id, ic, ib, ia} = sel;

   // current byte slot for packing, read-modify-write of a buffer word
   logic [7:0]  fpos;
   logic [7:0]  cur_byte;
   assign fpos = fill_ff;
   assign cur_byte = 8'(word_ff >> {pos_ff[2:0], 3'b000});

   // a register write in idle takes precedence over a message beat
   assign req.ready = (state_ff == ST_IDLE) && !csr.valid;
   assign csr.ready = (state_ff == ST_IDLE);

   always_comb begin
      bw_en = 1'b0;
      bw_addr = fpos[6:3];
      bw_data = br_data;
      br_addr = fpos[6:3];
      case (state_ff)
         ST_PACK: begin
            // reads are issued in sub_ff phase 0, ahead of the phase 1 write
            if (sub_ff[0]) begin
               bw_en = 1'b1;
               bw_data = br_data;
               bw_data[{fpos[2:0], 3'b000} +: 8] = (pos_ff < nb_ff) ? cur_byte : 8'd0;
               if (fpos[2:0] == 3'd0) begin
                  bw_data = {56'd0, (pos_ff < nb_ff) ? cur_byte : 8'd0};
               end
            end
         end
         ST_RD0: br_addr = b2b_pkg::sigma(round_ff, {g_ff, 1'b0});
         ST_RD1: br_addr = b2b_pkg::sigma(round_ff, {g_ff, 1'b1});
         default: ;
      endcase
   end

   // mix step: four sub-steps per half of g
   logic [63:0] va, vb, vc, vd, t;
   always_comb begin
      va = v_ff[ia]; vb = v_ff[ib]; vc = v_ff[ic]; vd = v_ff[id];
      t = '0;
      case (sub_ff)
         4'd0: t = va + vb + m0_ff;
         4'd1: begin t = vd ^ va; t = {t[31:0], t[63:32]}; end
         4'd2: t = vc + vd;
         4'd3: begin t = vb ^ vc; t = {t[23:0], t[63:24]}; end
         4'd4: t = va + vb + m1_ff;
         4'd5: begin t = vd ^ va; t = {t[15:0], t[63:16]}; end
         4'd6: t = vc + vd;
         default: begin t = vb ^ vc; t = {t[62:0], t[63]}; end
      endcase
   end

   logic [3:0] tgt;
   always_comb begin
      case (sub_ff[1:0])
         2'd0: tgt = ia;
         2'd1: tgt = id;
         2'd2: tgt = ic;
         default: tgt = ib;
      endcase
   end

   logic [63:0] pw;
   assign pw = b2b_pkg::param_word(dlen_ff, klen_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dlen_ff <= 7'd64;
         klen_ff <= 7'd0;
         cnt_ff <= '0;
         fill_ff <= '0;
         for (int i = 1; i < 8; i++) cv_ff[i] <= b2b_pkg::iv_word(3'(i));
         cv_ff[0] <= b2b_pkg::iv_word(3'd0) ^ b2b_pkg::param_word(7'd64, 7'd0);
         rsp.valid <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (csr.valid) begin
                  // register write restarts the engine
                  if (csr.index == b2b_pkg::CSR_DIGEST_LEN) dlen_ff <= csr.data;
                  else klen_ff <= csr.data;
                  for (int i = 1; i < 8; i++) cv_ff[i] <= b2b_pkg::iv_word(3'(i));
                  cv_ff[0] <= b2b_pkg::iv_word(3'd0) ^ b2b_pkg::param_word(
                     (csr.index == b2b_pkg::CSR_DIGEST_LEN) ? csr.data : dlen_ff,
                     (csr.index == b2b_pkg::CSR_KEY_LEN) ? csr.data : klen_ff);
                  cnt_ff <= '0;
                  fill_ff <= '0;
               end else if (req.valid) begin
                  word_ff <= req.msg_word;
                  nb_ff <= (req.valid_bytes > 4'd8) ? 4'd8 : req.valid_bytes;
                  last_ff <= req.last_word;
                  pos_ff <= '0;
                  sub_ff <= '0;
                  state_ff <= ST_PACK;
               end
            end
            ST_PACK: begin
               // phase 0 issues read, phase 1 writes byte
               if (!sub_ff[0]) begin
                  if (pos_ff < nb_ff) begin
                     if (fill_ff[7]) begin
                        final_ff <= 1'b0;
                        state_ff <= ST_INIT;
                     end else sub_ff <= 4'd1;
                  end else if (last_ff) begin
                     if (fill_ff[7]) begin
                        final_ff <= 1'b1;
                        state_ff <= ST_INIT;
                     end else sub_ff <= 4'd1;
                  end else state_ff <= ST_IDLE;
               end else begin
                  sub_ff <= '0;
                  if (pos_ff < nb_ff) begin
                     // the counter tracks message bytes only, never padding
                     pos_ff <= pos_ff + 4'd1;
                     cnt_ff <= cnt_ff + 128'd1;
                  end
                  fill_ff <= fill_ff + 8'd1;
               end
            end
            ST_INIT: begin
               for (int i = 0; i < 8; i++) v_ff[i] <= cv_ff[i];
               for (int i = 0; i < 4; i++) v_ff[i+8] <= b2b_pkg::iv_word(3'(i));
               v_ff[12] <= b2b_pkg::iv_word(3'd4) ^ cnt_ff[63:0];
               v_ff[13] <= b2b_pkg::iv_word(3'd5) ^ cnt_ff[127:64];
               v_ff[14] <= b2b_pkg::iv_word(3'd6) ^ {64{final_ff}};
               v_ff[15] <= b2b_pkg::iv_word(3'd7);
               if (!final_ff) fill_ff <= '0;
               round_ff <= '0;
               g_ff <= '0;
               state_ff <= ST_RD0;
            end
            ST_RD0: state_ff <= ST_RD1;
            ST_RD1: begin m0_ff <= br_data; state_ff <= ST_RD2; end
            ST_RD2: begin m1_ff <= br_data; sub_ff <= '0; state_ff <= ST_MIX; end
            ST_MIX: begin
               v_ff[tgt] <= t;
               sub_ff <= sub_ff + 4'd1;
               if (sub_ff == 4'd7) begin
                  g_ff <= g_ff + 3'd1;
                  state_ff <= ST_RD0;
                  if (g_ff == 3'd7) begin
                     round_ff <= round_ff + 4'd1;
                     if (round_ff == 4'd11) state_ff <= ST_FIN;
                  end
               end
            end
            ST_FIN: begin
               for (int i = 0; i < 8; i++) cv_ff[i] <= cv_ff[i] ^ v_ff[i] ^ v_ff[i+8];
               if (final_ff) begin
                  ow_ff <= '0;
                  state_ff <= ST_OUT;
               end else begin
                  sub_ff <= '0;
                  state_ff <= ST_PACK;
               end
            end
            ST_OUT: begin
               if (!rsp.valid || rsp.ready) begin
                  if (rsp.valid && rsp.digest_last) begin
                     rsp.valid <= 1'b0;
                     for (int i = 1; i < 8; i++) cv_ff[i] <= b2b_pkg::iv_word(3'(i));
                     cv_ff[0] <= b2b_pkg::iv_word(3'd0) ^ pw;
                     cnt_ff <= '0;
                     fill_ff <= '0;
                     state_ff <= ST_IDLE;
                  end else begin
                     rsp.valid <= 1'b1;
                     rsp.digest_last <= (ow_ff == last_ow);
                     if (ow_ff == last_ow && dl_eff[2:0] != 3'd0) begin
                        rsp.digest_bytes <= {1'b0, dl_eff[2:0]};
                        rsp.digest_word <= cv_ff[ow_ff] &
                           ~(64'hffff_ffff_ffff_ffff << {dl_eff[2:0], 3'b000});
                     end else begin
                        rsp.digest_bytes <= 4'd8;
                        rsp.digest_word <= cv_ff[ow_ff];
                     end
                     ow_ff <= ow_ff + 3'd1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // final padding: packing continues with zero bytes until the block is full
   // (handled by the pos_ff >= nb_ff path above when last_ff is set)

`ifndef SYNTHESIS
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 8'd128) else $error("fill above block size");
   a_rsp_only_out: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> state_ff == ST_OUT) else $error("digest outside output phase");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MIX |-> !req.ready) else $error("accept during compression");
`endif

endmodule

>>> dv/blake2b_hash_engine_tb.sv
`timescale 1ns / 100ps
// self-checking testbench of the blake2b hash engine: digest predictor, random traffic, stalls
module blake2b_hash_engine_tb;

   typedef struct {
      logic [63:0] word;
      logic [3:0]  nbytes;
      logic        last;
   } digest_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   b2b_req_if req_ch();
   b2b_rsp_if rsp_ch();
   b2b_csr_if csr_ch();

   blake2b_hash_engine uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // hash constants and schedules, kept here independent of the design
   logic [63:0] iv_tab [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
   int msg_sched [10][16] = '{
      '{ 0,  1,  2,  3,  4,  5,  6,  7,  8,  9, 10, 11, 12, 13, 14, 15},
      '{14, 10,  4,  8,  9, 15, 13,  6,  1, 12,  0,  2, 11,  7,  5,  3},
      '{11,  8, 12,  0,  5,  2, 15, 13, 10, 14,  3,  6,  7,  1,  9,  4},
      '{ 7,  9,  3,  1, 13, 12, 11, 14,  2,  6,  5, 10,  4,  0, 15,  8},
      '{ 9,  0,  5,  7,  2,  4, 10, 15, 14,  1, 11, 12,  6,  8,  3, 13},
      '{ 2, 12,  6, 10,  0, 11,  8,  3,  4, 13,  7,  5, 15, 14,  1,  9},
      '{12,  5,  1, 15, 14, 13,  4, 10,  0,  7,  6,  3,  9,  2,  8, 11},
      '{13, 11,  7, 14, 12,  1,  3,  9,  5,  0, 15,  4,  8,  6,  2, 10},
      '{ 6, 15, 14,  9, 11,  3,  0,  8, 12,  2, 13,  7,  1,  4, 10,  5},
      '{10,  2,  8,  4,  7,  6,  1,  5, 15, 11,  9, 14,  3, 12, 13,  0}};
   int mix_cols [8][4] = '{
      '{0, 4,  8, 12}, '{1, 5,  9, 13}, '{2, 6, 10, 14}, '{3, 7, 11, 15},
      '{0, 5, 10, 15}, '{1, 6, 11, 12}, '{2, 7,  8, 13}, '{3, 4,  9, 14}};

   // predictor state
   logic [6:0]   digest_len_reg = 7'd64;
   logic [6:0]   key_len_reg    = 7'd0;
   logic [63:0]  chain [8];
   logic [7:0]   block_bytes [128];
   logic [127:0] byte_total;
   int           fill;

   digest_beat_type digest_queue [$];
   int           errors      = 0;
   int           words_sent  = 0;
   int           hold_cycles = 0;
   bit           idle_on     = 1'b1;

   function automatic int digest_size();
      if (digest_len_reg == 7'd0) return 1;
      if (digest_len_reg > 7'd64) return 64;
      return int'(digest_len_reg);
   endfunction

   function automatic int key_size();
      return (key_len_reg > 7'd64) ? 64 : int'(key_len_reg);
   endfunction

   function automatic void restart_chain();
      for (int i = 0; i < 8; i++) chain[i] = iv_tab[i];
      chain[0] ^= 64'h0101_0000 ^ (64'(key_size()) << 8) ^ 64'(digest_size());
      byte_total = '0;
      fill = 0;
   endfunction

   function automatic logic [63:0] rotr(logic [63:0] x, int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function automatic void compress_block(bit final_block);
      logic [63:0] v [16];
      logic [63:0] m [16];
      logic [63:0] x, y;
      int a, b, c, d;
      for (int i = 0; i < 16; i++)
         for (int j = 0; j < 8; j++) m[i][8*j +: 8] = block_bytes[8*i + j];
      for (int i = 0; i < 8; i++) begin
         v[i]     = chain[i];
         v[i + 8] = iv_tab[i];
      end
      v[12] ^= byte_total[63:0];
      v[13] ^= byte_total[127:64];
      if (final_block) v[14] = ~v[14];
      for (int r = 0; r < 12; r++) begin
         for (int g = 0; g < 8; g++) begin
            a = mix_cols[g][0]; b = mix_cols[g][1]; c = mix_cols[g][2]; d = mix_cols[g][3];
            x = m[msg_sched[r % 10][2*g]];
            y = m[msg_sched[r % 10][2*g + 1]];
            v[a] = v[a] + v[b] + x;
            v[d] = rotr(v[d] ^ v[a], 32);
            v[c] = v[c] + v[d];
            v[b] = rotr(v[b] ^ v[c], 24);
            v[a] = v[a] + v[b] + y;
            v[d] = rotr(v[d] ^ v[a], 16);
            v[c] = v[c] + v[d];
            v[b] = rotr(v[b] ^ v[c], 63);
         end
      end
      for (int i = 0; i < 8; i++) chain[i] ^= v[i] ^ v[i + 8];
   endfunction

   // absorb one accepted beat; a last beat queues the digest words
   function automatic void absorb_word(logic [63:0] word, logic [3:0] nb_in, logic last);
      int nb, dl, nwords, cnt;
      digest_beat_type beat;
      nb = (nb_in > 4'd8) ? 8 : int'(nb_in);
      for (int i = 0; i < nb; i++) begin
         // a full block only compresses once a further byte shows up
         if (fill >= 128) begin
            byte_total += 128'd128;
            compress_block(1'b0);
            fill = 0;
         end
         block_bytes[fill] = word[8*i +: 8];
         fill++;
      end
      if (!last) return;
      byte_total += 128'(fill);
      for (int i = fill; i < 128; i++) block_bytes[i] = 8'h00;
      compress_block(1'b1);
      dl = digest_size();
      nwords = (dl + 7) / 8;
      for (int k = 0; k < nwords; k++) begin
         cnt = (dl - 8*k > 8) ? 8 : dl - 8*k;
         beat.word = chain[k];
         if (cnt < 8) beat.word &= (64'd1 << (8*cnt)) - 64'd1;
         beat.nbytes = 4'(cnt);
         beat.last = (k + 1 == nwords);
         digest_queue.push_back(beat);
      end
      restart_chain();
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   // digest checker and receiver stall generator
   initial begin
      digest_beat_type exp_beat;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (digest_queue.size() == 0) begin
               $error("digest beat with none expected: word %h", rsp_ch.digest_word);
               errors++;
            end else begin
               exp_beat = digest_queue.pop_front();
               if (rsp_ch.digest_word !== exp_beat.word) begin
                  $error("digest_word: expected %h, actual %h", exp_beat.word, rsp_ch.digest_word);
                  errors++;
               end
               if (rsp_ch.digest_bytes !== exp_beat.nbytes) begin
                  $error("digest_bytes: expected %0d, actual %0d",
                         exp_beat.nbytes, rsp_ch.digest_bytes);
                  errors++;
               end
               if (rsp_ch.digest_last !== exp_beat.last) begin
                  $error("digest_last: expected %0d, actual %0d",
                         exp_beat.last, rsp_ch.digest_last);
                  errors++;
               end
            end
         end
         @(negedge clock);
         // a long hold-off is counted down here, cycle by cycle
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !(idle_on && $urandom_range(99) < 16);
         end
      end
   end

   // one message beat: optional idle gap, then hold valid until accepted
   task automatic send_word(logic [63:0] word, logic [3:0] nb, logic last);
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 16) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.msg_word    <= word;
      req_ch.valid_bytes <= nb;
      req_ch.last_word   <= last;
      do @(posedge clock); while (!req_ch.ready);
      absorb_word(word, nb, last);
      words_sent++;
   endtask

   task automatic drop_valid();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   // sender pause until every digest beat is back
   task automatic wait_drain();
      drop_valid();
      while (digest_queue.size() != 0) @(posedge clock);
   endtask

   // registers only change with the engine idle; a trailing block compress may still run
   task automatic write_reg(logic [0:0] idx, logic [6:0] value);
      wait_drain();
      repeat (500) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      if (idx == b2b_pkg::CSR_DIGEST_LEN) digest_len_reg = value;
      else key_len_reg = value;
      // a write restarts the engine and drops any partial message
      restart_chain();
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // key block: key bytes then zeros up to 128 bytes
   task automatic send_key_block();
      logic [63:0] w;
      for (int i = 0; i < 16; i++) begin
         w = rand_word();
         for (int j = 0; j < 8; j++)
            if (8*i + j >= key_size()) w[8*j +: 8] = 8'h00;
         send_word(w, 4'd8, 1'b0);
      end
   endtask

   task automatic send_message(int nwords, logic [3:0] last_nb);
      logic [3:0] nb;
      for (int i = 0; i < nwords; i++) begin
         if (i == nwords - 1) nb = last_nb;
         else nb = ($urandom_range(99) < 10) ? 4'($urandom_range(15)) : 4'd8;
         send_word(rand_word(), nb, i == nwords - 1);
      end
   endtask

   task automatic test_directed();
      // empty message and short, full and oversize words at default lengths
      send_word(64'h0, 4'd0, 1'b1);
      send_word(64'h0000_0000_0063_6261, 4'd3, 1'b1);
      send_word(64'hffff_ffff_ffff_ffff, 4'd15, 1'b1);
      send_word(64'h0, 4'd8, 1'b1);
      // short word that is not last packs without gaps
      send_word(64'hffff_ffff_ffff_ffff, 4'd5, 1'b0);
      send_word(64'h8000_0000_0000_0001, 4'd8, 1'b1);
      // digest length sweep, zero and oversize clamp
      write_reg(b2b_pkg::CSR_DIGEST_LEN, 7'd0);
      send_word(64'h0, 4'd0, 1'b1);
      write_reg(b2b_pkg::CSR_DIGEST_LEN, 7'd1);
      send_word(64'h5a, 4'd1, 1'b1);
      write_reg(b2b_pkg::CSR_DIGEST_LEN, 7'd9);
      send_word(64'h1234, 4'd2, 1'b1);
      write_reg(b2b_pkg::CSR_DIGEST_LEN, 7'd127);
      send_word(64'h0, 4'd0, 1'b1);
      // oversize key length clamps to 64; empty keyed message
      write_reg(b2b_pkg::CSR_KEY_LEN, 7'd127);
      send_word(64'h0, 4'd0, 1'b1);
      write_reg(b2b_pkg::CSR_KEY_LEN, 7'd0);
      // register write in mid-message drops the partial data
      send_word(64'hdead_beef_cafe_f00d, 4'd8, 1'b0);
      write_reg(b2b_pkg::CSR_DIGEST_LEN, 7'd32);
      send_word(64'h0102_0304_0506_0708, 4'd8, 1'b1);
   endtask

   task automatic test_random_messages(int target);
      int msg_no, nwords, r;
      logic [3:0] last_nb;
      msg_no = 0;
      while (words_sent < target) begin
         if (msg_no % 4 == 0) begin
            r = $urandom_range(99);
            write_reg(b2b_pkg::CSR_DIGEST_LEN, (r < 15) ? 7'd64 : (r < 25) ? 7'd0 :
                      (r < 30) ? 7'd127 : 7'($urandom_range(127)));
            r = $urandom_range(99);
            write_reg(b2b_pkg::CSR_KEY_LEN, (r < 50) ? 7'd0 : (r < 60) ? 7'd64 :
                      (r < 65) ? 7'd127 : 7'($urandom_range(127)));
         end
         // a stretch of messages with no idling on either side
         idle_on = (msg_no % 8 < 5);
         if (key_len_reg != 7'd0) send_key_block();
         r = $urandom_range(99);
         if (r < 60) nwords = $urandom_range(6, 1);
         else if (r < 85) nwords = $urandom_range(20, 7);
         else nwords = $urandom_range(18, 15);
         last_nb = ($urandom_range(99) < 10) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
         send_message(nwords, last_nb);
         msg_no++;
      end
      idle_on = 1'b1;
   endtask

   // receiver holds off while messages keep coming, then the sender drains
   task automatic test_backpressure();
      write_reg(b2b_pkg::CSR_KEY_LEN, 7'd0);
      write_reg(b2b_pkg::CSR_DIGEST_LEN, 7'd64);
      hold_cycles = 3000;
      for (int i = 0; i < 4; i++) send_message(3, 4'd8);
      wait_drain();
   endtask

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.msg_word    = '0;
      req_ch.valid_bytes = '0;
      req_ch.last_word   = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = b2b_pkg::CSR_DIGEST_LEN;
      csr_ch.data        = '0;
      restart_chain();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_backpressure();
      test_random_messages(220);

      wait_drain();
      repeat (500) @(posedge clock);
      if (errors == 0) $display("blake2b_hash_engine verification clean");
      else $display("blake2b_hash_engine verification failed");
      $finish;
   end

   // run limit, far above the slowest passing run
   initial begin
      #20_000_000;
      $display("blake2b_hash_engine verification failed");
      $finish;
   end

endmodule
